/* src/lgs_pkg.sv */
// Shared types and command codes for the toroidal life grid block.
`timescale 1ns / 1ps
package lgs_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_TOGGLE = 2'd1;
  localparam logic [1:0] CMD_STEP   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [6:0] SIZE_MIN   = 7'd3;
  localparam logic [6:0] SIZE_RESET = 7'd50;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] column;
    logic       value;
  } in_t;

  typedef struct packed {
    logic        cell_res;
    logic [31:0] generation;
  } out_t;

  // One classified command waiting for the engine.
  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] column;
    logic       value;
    logic       in_grid;
    logic [6:0] size;
  } task_t;

  // Engine status seen by the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

/* src/lgs_front.sv */
// Front end: accepts commands, holds the grid size register and classifies each beat.
`timescale 1ns / 1ps
module lgs_front #(
  parameter int GRID_DIM = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lgs_pkg::in_t         in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data,
  input  lgs_pkg::back_status_t status,
  input  logic                 q_full,
  output logic                 q_push,
  output lgs_pkg::task_t       q_data
);

  logic [6:0] grid_size_r;
  logic [6:0] size_use;

  assign cfg_ready = 1'b1;

  // Hold the size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= lgs_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      grid_size_r <= cfg_data;
    end
  end

  // Clamp the size into the legal range.
  always_comb begin
    if (grid_size_r < lgs_pkg::SIZE_MIN) begin
      size_use = lgs_pkg::SIZE_MIN;
    end else if (32'(grid_size_r) > GRID_DIM) begin
      size_use = 7'(GRID_DIM);
    end else begin
      size_use = grid_size_r;
    end
  end

  assign in_ready = !q_full && !status.clearing;
  assign q_push   = in_valid && in_ready;

  // Classify the beat.
  always_comb begin
    q_data.command = in_data.command;
    q_data.row     = in_data.row;
    q_data.column  = in_data.column;
    q_data.value   = in_data.value;
    q_data.size    = size_use;
    q_data.in_grid = ({1'b0, in_data.row} < size_use) && ({1'b0, in_data.column} < size_use);
  end

endmodule

/* src/lgs_queue.sv */
// Two-entry queue between the front end and the engine.
`timescale 1ns / 1ps
module lgs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lgs_pkg::task_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lgs_pkg::task_t pop_data
);

  lgs_pkg::task_t slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rp_r];

  // Store incoming beats.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/lgs_back.sv */
// Engine: row-wide grid memory, cell commands, generation sweep and result register.
`timescale 1ns / 1ps
module lgs_back #(
  parameter int GRID_DIM = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  lgs_pkg::task_t        q_data,
  output logic                  q_pop,
  output lgs_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lgs_pkg::out_t         out_data
);

  localparam int AW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CELL  = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_R0    = 3'd4;
  localparam logic [2:0] S_R1    = 3'd5;
  localparam logic [2:0] S_ROW   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [GRID_DIM-1:0] mem [GRID_DIM];

  logic [2:0]          state_r, state_nxt;
  lgs_pkg::task_t      task_r;
  logic [GRID_DIM-1:0] rd_data_r, prev_r, cur_r, row0_r;
  logic [AW-1:0]       r_r, clr_r;
  logic [31:0]         gen_r;
  logic                res_r;
  lgs_pkg::out_t       out_r;
  logic                out_valid_r;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [GRID_DIM-1:0] mem_wd;

  logic [AW-1:0]       nm1;
  logic [AW-1:0]       col_idx;
  logic [GRID_DIM-1:0] cell_row;
  logic [GRID_DIM-1:0] dn_row;
  logic [GRID_DIM-1:0] new_row;
  logic                out_free;

  assign nm1      = AW'(task_r.size - 7'd1);
  assign col_idx  = AW'(task_r.column);
  assign dn_row   = (r_r == nm1) ? row0_r : rd_data_r;
  assign out_free = !out_valid_r || out_ready;

  assign status.clearing = (state_r == S_CLEAR);
  assign q_pop           = (state_r == S_IDLE) && !q_empty;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  // Left and right neighbor vectors with wrap at the size in use.
  function automatic logic [GRID_DIM-1:0] left_of(logic [GRID_DIM-1:0] v, logic [AW-1:0] last);
    left_of = {v[GRID_DIM-2:0], v[last]};
  endfunction

  function automatic logic [GRID_DIM-1:0] right_of(logic [GRID_DIM-1:0] v, logic [AW-1:0] last);
    logic [GRID_DIM-1:0] t;
    t       = {v[0], v[GRID_DIM-1:1]};
    t[last] = v[0];
    right_of = t;
  endfunction

  // Apply the rule to every lane below the size in use; other lanes keep their value.
  always_comb begin
    logic [GRID_DIM-1:0] ul, ur, cl, cr, dl, dr;
    logic [3:0] cnt;
    ul = left_of(prev_r, nm1);
    ur = right_of(prev_r, nm1);
    cl = left_of(cur_r, nm1);
    cr = right_of(cur_r, nm1);
    dl = left_of(dn_row, nm1);
    dr = right_of(dn_row, nm1);
    new_row = cur_r;
    for (int c = 0; c < GRID_DIM; c++) begin
      cnt = 4'(ul[c]) + 4'(prev_r[c]) + 4'(ur[c]) + 4'(cl[c]) + 4'(cr[c])
          + 4'(dl[c]) + 4'(dn_row[c]) + 4'(dr[c]);
      if (c < 32'(task_r.size)) begin
        new_row[c] = cur_r[c] ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == 4'd3);
      end
    end
  end

  // Modify the addressed cell of the fetched row.
  always_comb begin
    cell_row = rd_data_r;
    case (task_r.command)
      lgs_pkg::CMD_WRITE:  cell_row[col_idx] = task_r.value;
      lgs_pkg::CMD_TOGGLE: cell_row[col_idx] = !rd_data_r[col_idx];
      default:             cell_row = rd_data_r;
    endcase
  end

  // Drive the memory ports.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = r_r;
    mem_wd = new_row;
    mem_re = 1'b0;
    mem_ra = AW'(q_data.row);
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      S_IDLE: begin
        mem_re = !q_empty && q_data.in_grid;
        mem_ra = AW'(q_data.row);
      end
      S_CELL: begin
        mem_we = (task_r.command == lgs_pkg::CMD_WRITE)
              || (task_r.command == lgs_pkg::CMD_TOGGLE);
        mem_wa = AW'(task_r.row);
        mem_wd = cell_row;
      end
      S_INIT: begin
        mem_re = 1'b1;
        mem_ra = nm1;
      end
      S_R0: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      S_R1: begin
        mem_re = 1'b1;
        mem_ra = AW'(1);
      end
      S_ROW: begin
        mem_we = 1'b1;
        mem_wa = r_r;
        mem_wd = new_row;
        mem_re = 1'b1;
        mem_ra = r_r + AW'(2);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Grid memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Sequence the commands.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(GRID_DIM - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty) begin
          if (q_data.command == lgs_pkg::CMD_STEP) begin
            state_nxt = S_INIT;
          end else if (q_data.in_grid) begin
            state_nxt = S_CELL;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_CELL:  state_nxt = S_RESP;
      S_INIT:  state_nxt = S_R0;
      S_R0:    state_nxt = S_R1;
      S_R1:    state_nxt = S_ROW;
      S_ROW: begin
        if (r_r == nm1) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == S_ROW && r_r == nm1) begin
        gen_r <= gen_r + 32'd1;
      end
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Advance the datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        task_r <= q_data;
        res_r  <= 1'b0;
      end
      S_CELL: begin
        res_r <= cell_row[col_idx];
      end
      S_R0: begin
        prev_r <= rd_data_r;
      end
      S_R1: begin
        cur_r  <= rd_data_r;
        row0_r <= rd_data_r;
        r_r    <= '0;
      end
      S_ROW: begin
        prev_r <= cur_r;
        cur_r  <= dn_row;
        r_r    <= r_r + AW'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_r.cell_res   <= res_r;
          out_r.generation <= gen_r;
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  // Checks.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE))
    else $error("queue popped while engine busy");

  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r != $past(gen_r)) |-> (gen_r == $past(gen_r) + 32'd1))
    else $error("generation count jumped");

  a_step_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW && r_r == nm1) |=> (res_r == 1'b0))
    else $error("step result cell not zero");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !mem_we)
    else $error("grid written outside a command");

endmodule

/* src/life_grid_generation_step.sv */
// Top level of the toroidal life grid: front end, queue and engine.
//
//   channel | direction | payload        | beat taken when
//   in_     | input     | lgs_pkg::in_t  | in_valid && in_ready
//   out_    | output    | lgs_pkg::out_t | out_valid && out_ready
//   cfg_    | input     | grid_size [6:0]| cfg_valid && cfg_ready
//
// After reset the engine clears the grid memory, one row a cycle, until all GRID_DIM rows are zero;
// no command beat is taken during that pass, configuration writes are.
// Write, toggle and read pass from queue to result register through memory read,
// modify and write back, and result load; a write, toggle or read outside the grid skips the memory steps.
// A step sweeps the grid row by row, writing each new row back while fetching rows ahead of it.
// The front end takes up to two beats ahead of the engine; a stalled result holds the engine.
`timescale 1ns / 1ps
module life_grid_generation_step #(
  parameter int GRID_DIM = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lgs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lgs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);

  lgs_pkg::back_status_t status;
  lgs_pkg::task_t        push_data, pop_data;
  logic                  q_push, q_pop, q_full, q_empty;

  lgs_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  lgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  lgs_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/life_grid_generation_step_test.sv */
// Testbench for the toroidal life grid: random commands checked against a behavioral grid.
`timescale 1ns / 1ps
module life_grid_generation_step_test;

  localparam int DIM = 64;
  localparam int CYCLE_LIMIT = 400000;

  // Behavioral grid and expected result queue
  class life_scoreboard;
    bit              grid [DIM*DIM];
    bit [31:0]       gen_count;
    bit [6:0]        size_reg;
    lgs_pkg::out_t   pending [$];
    int              error_count;
    int              beats_checked;

    function void clear_all();
      foreach (grid[i]) grid[i] = 0;
      gen_count = 0;
      size_reg = lgs_pkg::SIZE_RESET;
    endfunction

    function int live_size();
      int n;
      n = size_reg;
      if (n < 3) n = 3;
      if (n > DIM) n = DIM;
      return n;
    endfunction

    function void advance_grid();
      bit nxt [DIM*DIM];
      int n, k, rr, cc;
      n = live_size();
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          k = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr == 0 && dc == 0) continue;
              rr = (r + dr + n) % n;
              cc = (c + dc + n) % n;
              k += grid[rr*DIM + cc];
            end
          nxt[r*DIM + c] = grid[r*DIM + c];
          if (!grid[r*DIM + c] && k == 3) nxt[r*DIM + c] = 1;
          else if (grid[r*DIM + c] && (k < 2 || k > 3)) nxt[r*DIM + c] = 0;
        end
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) grid[r*DIM + c] = nxt[r*DIM + c];
      gen_count++;
    endfunction

    // Print one mismatch line and count it
    task report_mismatch(string what, longint got, longint exp);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $time);
      error_count++;
    endtask

    // Note an accepted command beat and queue its expected result
    function void note_command(lgs_pkg::in_t cmd);
      lgs_pkg::out_t exp;
      int n, a;
      n = live_size();
      exp.cell_res = 0;
      if (cmd.command == lgs_pkg::CMD_STEP) advance_grid();
      else if (cmd.row < n && cmd.column < n) begin
        a = cmd.row*DIM + cmd.column;
        if (cmd.command == lgs_pkg::CMD_WRITE) grid[a] = cmd.value;
        else if (cmd.command == lgs_pkg::CMD_TOGGLE) grid[a] = ~grid[a];
        exp.cell_res = grid[a];
      end
      exp.generation = gen_count;
      pending.push_back(exp);
    endfunction

    // Check one result beat against the oldest expectation
    task check_result(lgs_pkg::out_t got);
      lgs_pkg::out_t exp;
      beats_checked++;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected", 0, 0);
        return;
      end
      exp = pending.pop_front();
      if (got.cell_res !== exp.cell_res)
        report_mismatch("cell_res", got.cell_res, exp.cell_res);
      if (got.generation !== exp.generation)
        report_mismatch("generation", got.generation, exp.generation);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  lgs_pkg::in_t  in_data;
  lgs_pkg::out_t out_data;
  logic [6:0] cfg_data;

  life_scoreboard sb;
  int cycle_count;

  life_grid_generation_step #(.GRID_DIM(DIM)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall per beat, check on each accepted beat
  initial begin : result_sink
    int hold;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_ready <= 0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
      sb.check_result(out_data);
    end
  end

  // Drive one command beat; valid stays up after the beat until the next gap or drain
  task automatic send_command(logic [1:0] op, int r, int c, bit v, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= '{command: op, row: r[5:0], column: c[5:0], value: v};
    @(posedge clk iff in_ready);
    sb.note_command('{command: op, row: r[5:0], column: c[5:0], value: v});
  endtask

  // Drop valid, wait for all results, then let the engine settle before a register write
  task automatic drain_queue();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_size(logic [6:0] s);
    cfg_valid <= 1;
    cfg_data  <= s;
    @(posedge clk iff cfg_ready);
    sb.size_reg = s;
    cfg_valid <= 0;
  endtask

  task automatic random_command(int n);
    int pick, r, c;
    pick = $urandom_range(0, 99);
    // mostly in range, sometimes anywhere in the 6-bit space
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    if (pick < 35)      send_command(lgs_pkg::CMD_WRITE, r, c, 1'($urandom), pick < 10);
    else if (pick < 50) send_command(lgs_pkg::CMD_TOGGLE, r, c, 1'($urandom));
    else if (pick < 68) send_command(lgs_pkg::CMD_STEP, r, c, 1'($urandom));
    else                send_command(lgs_pkg::CMD_READ, r, c, 1'($urandom), pick > 90);
  endtask

  // Glider at an offset, stepped, read back
  task automatic glider_run(int n);
    int r0, c0;
    r0 = $urandom_range(0, n - 1);
    c0 = $urandom_range(0, n - 1);
    send_command(lgs_pkg::CMD_WRITE, r0, (c0 + 1) % n, 1);
    send_command(lgs_pkg::CMD_WRITE, (r0 + 1) % n, (c0 + 2) % n, 1);
    send_command(lgs_pkg::CMD_WRITE, (r0 + 2) % n, c0, 1, 1);
    send_command(lgs_pkg::CMD_WRITE, (r0 + 2) % n, (c0 + 1) % n, 1);
    send_command(lgs_pkg::CMD_WRITE, (r0 + 2) % n, (c0 + 2) % n, 1);
    repeat (2) send_command(lgs_pkg::CMD_STEP, 0, 0, 0);
    for (int i = 0; i < 3; i++)
      send_command(lgs_pkg::CMD_READ, (r0 + 2 + i) % n, (c0 + 2) % n, 0, 1);
  endtask

  initial begin : stimulus
    logic [6:0] sizes [6];
    int n;
    sb = new();
    sb.clear_all();
    cycle_count = 0;
    in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: corners, out of range, blinker across the wrap, toggles
    n = 50;
    send_command(lgs_pkg::CMD_READ, 0, 0, 0);
    send_command(lgs_pkg::CMD_WRITE, 0, 0, 1);
    send_command(lgs_pkg::CMD_WRITE, 49, 49, 1);
    send_command(lgs_pkg::CMD_WRITE, 63, 63, 1);
    send_command(lgs_pkg::CMD_TOGGLE, 50, 0, 0);
    send_command(lgs_pkg::CMD_READ, 0, 63, 0);
    send_command(lgs_pkg::CMD_TOGGLE, 49, 49, 0);
    send_command(lgs_pkg::CMD_WRITE, 0, 49, 1);
    send_command(lgs_pkg::CMD_WRITE, 0, 1, 1);
    send_command(lgs_pkg::CMD_STEP, 63, 63, 1);
    send_command(lgs_pkg::CMD_READ, 49, 0, 0);
    send_command(lgs_pkg::CMD_READ, 1, 0, 0);
    send_command(lgs_pkg::CMD_STEP, 0, 0, 0);
    send_command(lgs_pkg::CMD_READ, 0, 49, 0);
    send_command(lgs_pkg::CMD_WRITE, 1, 1, 0);
    send_command(lgs_pkg::CMD_TOGGLE, 2, 2, 1);
    send_command(lgs_pkg::CMD_READ, 2, 2, 1);
    drain_queue();

    // Random phases over several sizes, extremes included
    sizes = '{7'd0, 7'd3, 7'd127, 7'd64, 7'd5, 7'd12};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      n = sb.live_size();
      glider_run(n);
      repeat (n > 12 ? 6 : 12) random_command(n);
      drain_queue();
    end
    write_size(lgs_pkg::SIZE_RESET);
    repeat (8) random_command(50);

    drain_queue();
    $display("covered %0d result beats over sizes 3..64, final generation %0d",
             sb.beats_checked, sb.gen_count);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
